// ===== sv/fwbc_pkg.sv =====
// Shared types and constants for the FIFO write-back sector cache.
// No dependencies; imported by the cache top, the checker and the testbench.
package fwbc_pkg;

  // Request action codes.
  typedef logic [1:0] action_t;
  localparam action_t ACT_READ   = 2'd0;
  localparam action_t ACT_WRITE  = 2'd1;
  localparam action_t ACT_MODIFY = 2'd2;
  localparam action_t ACT_FLUSH  = 2'd3;

  // Payload types.
  typedef logic [15:0]        sector_t;
  typedef logic signed [31:0] word_t;

  // Modify step values and the zero word.
  localparam word_t WORD_ZERO  = 32'sd0;
  localparam word_t WORD_PLUS  = 32'sd1;
  localparam word_t WORD_MINUS = -32'sd1;

  // Default number of cache slots.
  localparam int DEFAULT_SLOT_COUNT = 8;

endpackage

// ===== sv/fifo_write_back_buffer_cache_top.sv =====
// Fully associative write-back sector cache with FIFO replacement and bypass mode.
// Depends on fwbc_pkg for action codes and payload types.
//
//   channel   signals                               direction
//   --------  ------------------------------------  ---------
//   request   in_valid/in_ready, action..modify_down  in
//   result    out_valid/out_ready, hit..last_result   out
//   config    cfg_write_en, cfg_write_data            in
//
// A lookup reads and then compares one filled slot at a time (S_SCAN, S_CMP) for
// read, write and modify; a flush emits one result per filled slot.
// One adder steps the modified value on both a hit and a fill; one comparator checks each scanned slot.
// Reset clears the mode, fill count, FIFO pointer and dirty bits; no clearing pass.
// Results wait in an output register; a stalled output holds the sequencer only
// at the step that emits a result, and a new request is taken while one waits.
module fifo_write_back_buffer_cache_top #(
  parameter int SLOT_COUNT = fwbc_pkg::DEFAULT_SLOT_COUNT
) (
  input  logic              clk,
  input  logic              rst,
  // Configuration
  input  logic              cfg_write_en,
  input  logic              cfg_write_data,
  // Request channel
  input  logic              in_valid,
  output logic              in_ready,
  input  fwbc_pkg::action_t action,
  input  fwbc_pkg::sector_t sector_address,
  input  fwbc_pkg::word_t   disk_data,
  input  logic              modify_down,
  // Result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic              hit,
  output logic              disk_read,
  output logic              write_valid,
  output fwbc_pkg::sector_t write_address,
  output fwbc_pkg::word_t   write_value,
  output logic              last_result
);
  import fwbc_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(SLOT_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(SLOT_COUNT - 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SCAN      = 3'd1;
  localparam logic [2:0] S_CMP       = 3'd2;
  localparam logic [2:0] S_MISS      = 3'd3;
  localparam logic [2:0] S_FILL      = 3'd4;
  localparam logic [2:0] S_EMIT      = 3'd5;
  localparam logic [2:0] S_FLUSH     = 3'd6;
  localparam logic [2:0] S_FLUSH_OUT = 3'd7;

  logic [2:0] state;

  // Latched request.
  action_t req_action;
  sector_t req_addr;
  word_t   req_data;
  logic    req_down;

  // Cache state.
  logic                  cache_mode;
  logic [CNT_W-1:0]      filled;
  logic [IDX_W-1:0]      oldest;
  logic [SLOT_COUNT-1:0] dirty;
  logic [CNT_W-1:0]      scan;
  logic                  evict;

  // Slot memories and their registered read data.
  sector_t slot_address_mem [SLOT_COUNT];
  word_t   slot_value_mem   [SLOT_COUNT];
  sector_t rd_addr;
  word_t   rd_value;

  // Staged single result.
  logic    res_hit;
  logic    res_disk_read;
  logic    res_write_valid;
  sector_t res_write_address;
  word_t   res_write_value;

  // Combinational control.
  logic             out_free;
  logic             emit;
  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] victim;
  logic [IDX_W-1:0] mem_ridx;
  logic             mem_we;
  sector_t          mem_waddr;
  word_t            mem_wvalue;
  word_t            add_base;
  word_t            add_result;
  logic             match;
  logic             wb_hit;
  logic             flush_last;

  assign in_ready   = (state == S_IDLE);
  assign out_free   = !out_valid || out_ready;
  assign scan_idx   = scan[IDX_W-1:0];
  assign victim     = (filled == FULL_COUNT) ? oldest : filled[IDX_W-1:0];
  assign mem_ridx   = (state == S_MISS) ? victim : scan_idx;
  assign match      = (rd_addr == req_addr);
  assign wb_hit     = (req_action == ACT_WRITE) && dirty[scan_idx];
  assign flush_last = ((scan + CNT_W'(1)) == filled);

  // A result is loaded into the output register in this cycle.
  assign emit = out_free && ((state == S_EMIT) || (state == S_FLUSH_OUT) ||
                             (state == S_FLUSH && filled == '0));

  // Shared increment/decrement unit for modify.
  assign add_base   = (state == S_CMP) ? rd_value : req_data;
  assign add_result = add_base + (req_down ? WORD_MINUS : WORD_PLUS);

  // Memory write: modify hit updates the value, a fill writes the whole slot.
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = req_addr;
    mem_wvalue = req_data;
    if (state == S_CMP && match && req_action == ACT_MODIFY) begin
      mem_we     = 1'b1;
      mem_wvalue = add_result;
    end else if (state == S_FILL) begin
      mem_we = 1'b1;
      if (req_action == ACT_MODIFY) begin
        mem_wvalue = add_result;
      end
    end
  end

  // Slot memories, one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_address_mem[scan_idx] <= mem_waddr;
      slot_value_mem[scan_idx]   <= mem_wvalue;
    end
    rd_addr  <= slot_address_mem[mem_ridx];
    rd_value <= slot_value_mem[mem_ridx];
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cache_mode <= 1'b0;
    end else if (cfg_write_en) begin
      cache_mode <= cfg_write_data;
    end
  end

  // Sequencer, cache bookkeeping and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      filled    <= '0;
      oldest    <= '0;
      dirty     <= '0;
      scan      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_action <= action;
            req_addr   <= sector_address;
            req_data   <= disk_data;
            req_down   <= modify_down;
            scan       <= '0;
            if (action == ACT_FLUSH) begin
              state <= S_FLUSH;
            end else if (cache_mode) begin
              // Bypass: reads fetch, writes and modifies write zero.
              res_hit           <= 1'b0;
              res_disk_read     <= (action == ACT_READ);
              res_write_valid   <= (action != ACT_READ);
              res_write_address <= (action == ACT_READ) ? '0 : sector_address;
              res_write_value   <= WORD_ZERO;
              state             <= S_EMIT;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // The read of slot scan is issued here; compare next cycle.
          state <= (scan == filled) ? S_MISS : S_CMP;
        end
        S_CMP: begin
          if (match) begin
            // Only a write hit on a dirty slot goes to the disk.
            res_hit           <= 1'b1;
            res_disk_read     <= 1'b0;
            res_write_valid   <= wb_hit;
            res_write_address <= wb_hit ? req_addr : '0;
            res_write_value   <= wb_hit ? rd_value : WORD_ZERO;
            if (req_action == ACT_MODIFY) begin
              dirty[scan_idx] <= 1'b1;
            end
            state <= S_EMIT;
          end else begin
            scan  <= scan + CNT_W'(1);
            state <= S_SCAN;
          end
        end
        S_MISS: begin
          if (req_action == ACT_WRITE) begin
            res_hit           <= 1'b0;
            res_disk_read     <= 1'b0;
            res_write_valid   <= 1'b0;
            res_write_address <= '0;
            res_write_value   <= WORD_ZERO;
            state             <= S_EMIT;
          end else begin
            // Pick the fill slot; the victim is read for a possible write-back.
            scan <= CNT_W'(victim);
            if (filled == FULL_COUNT) begin
              evict  <= dirty[victim];
              oldest <= (oldest == LAST_IDX) ? '0 : oldest + IDX_W'(1);
            end else begin
              evict  <= 1'b0;
              filled <= filled + CNT_W'(1);
            end
            state <= S_FILL;
          end
        end
        S_FILL: begin
          dirty[scan_idx]   <= (req_action == ACT_MODIFY);
          res_hit           <= 1'b0;
          res_disk_read     <= 1'b1;
          res_write_valid   <= evict;
          res_write_address <= evict ? rd_addr : '0;
          res_write_value   <= evict ? rd_value : WORD_ZERO;
          state             <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            hit           <= res_hit;
            disk_read     <= res_disk_read;
            write_valid   <= res_write_valid;
            write_address <= res_write_address;
            write_value   <= res_write_value;
            last_result   <= 1'b1;
            state         <= S_IDLE;
          end
        end
        S_FLUSH: begin
          if (filled == '0) begin
            // Empty cache gives a single empty result.
            if (out_free) begin
              hit           <= 1'b0;
              disk_read     <= 1'b0;
              write_valid   <= 1'b0;
              write_address <= '0;
              write_value   <= WORD_ZERO;
              last_result   <= 1'b1;
              oldest        <= '0;
              state         <= S_IDLE;
            end
          end else begin
            state <= S_FLUSH_OUT;
          end
        end
        S_FLUSH_OUT: begin
          if (out_free) begin
            hit             <= 1'b0;
            disk_read       <= 1'b0;
            write_valid     <= dirty[scan_idx];
            write_address   <= dirty[scan_idx] ? rd_addr : '0;
            write_value     <= dirty[scan_idx] ? rd_value : WORD_ZERO;
            last_result     <= flush_last;
            dirty[scan_idx] <= 1'b0;
            if (flush_last) begin
              filled <= '0;
              oldest <= '0;
              state  <= S_IDLE;
            end else begin
              scan  <= scan + CNT_W'(1);
              state <= S_FLUSH;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== verif/sector_cache_checker.sv =====
// Checker for the FIFO write-back sector cache: watches the request, result and
// configuration ports, predicts every result and compares it field by field.
// Depends on fwbc_pkg for action codes and payload types.
module sector_cache_checker #(
  parameter int SLOT_COUNT = fwbc_pkg::DEFAULT_SLOT_COUNT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_en,
  input  logic              cfg_write_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  fwbc_pkg::action_t action,
  input  fwbc_pkg::sector_t sector_address,
  input  fwbc_pkg::word_t   disk_data,
  input  logic              modify_down,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              hit,
  input  logic              disk_read,
  input  logic              write_valid,
  input  fwbc_pkg::sector_t write_address,
  input  fwbc_pkg::word_t   write_value,
  input  logic              last_result,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import fwbc_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic    hit;
    logic    disk_read;
    logic    write_valid;
    sector_t write_address;
    word_t   write_value;
    logic    last_result;
  } sector_result_t;

  // Shadow copy of the cache contents and mode.
  sector_t slot_sector [SLOT_COUNT];
  word_t   slot_word   [SLOT_COUNT];
  logic    slot_dirty  [SLOT_COUNT];
  int      fill_count;
  int      fifo_ptr;
  logic    bypass;

  sector_result_t expected_results[$];

  // Takes a slot for a missed sector, evicting the oldest one when full.
  function automatic int claim_slot(sector_t addr, word_t data, output logic wb,
                                    output sector_t wb_addr, output word_t wb_val);
    int s;
    wb = 1'b0;
    wb_addr = '0;
    wb_val = WORD_ZERO;
    if (fill_count < SLOT_COUNT) begin
      s = fill_count;
      fill_count++;
    end else begin
      s = fifo_ptr % SLOT_COUNT;
      if (slot_dirty[s]) begin
        wb = 1'b1;
        wb_addr = slot_sector[s];
        wb_val = slot_word[s];
      end
      fifo_ptr = (s + 1) % SLOT_COUNT;
    end
    slot_sector[s] = addr;
    slot_word[s] = data;
    slot_dirty[s] = 1'b0;
    return s;
  endfunction

  // Works out the results of one accepted request and queues them.
  task automatic predict_request(action_t act, sector_t addr, word_t data, logic down);
    sector_result_t r;
    int pos;
    logic wb;
    sector_t wb_addr;
    word_t wb_val;
    r = '0;
    r.last_result = 1'b1;
    pos = -1;

    // Flush walks every filled slot in either mode.
    if (act == ACT_FLUSH) begin
      for (int i = 0; i < fill_count; i++) begin
        r = '0;
        if (slot_dirty[i]) begin
          r.write_valid = 1'b1;
          r.write_address = slot_sector[i];
          r.write_value = slot_word[i];
        end
        r.last_result = (i + 1 == fill_count);
        slot_dirty[i] = 1'b0;
        expected_results = {expected_results, r};
      end
      if (fill_count == 0) begin
        r = '0;
        r.last_result = 1'b1;
        expected_results = {expected_results, r};
      end
      fill_count = 0;
      fifo_ptr = 0;
      return;
    end

    // Bypass goes straight to the disk and leaves the slots alone.
    if (bypass) begin
      if (act == ACT_READ) begin
        r.disk_read = 1'b1;
      end else begin
        r.write_valid = 1'b1;
        r.write_address = addr;
      end
      expected_results = {expected_results, r};
      return;
    end

    for (int i = 0; i < fill_count; i++) begin
      if (pos < 0 && slot_sector[i] == addr) begin
        pos = i;
      end
    end

    case (act)
      ACT_READ: begin
        if (pos >= 0) begin
          r.hit = 1'b1;
        end else begin
          void'(claim_slot(addr, data, wb, wb_addr, wb_val));
          r.disk_read = 1'b1;
          r.write_valid = wb;
          r.write_address = wb_addr;
          r.write_value = wb_val;
        end
      end
      ACT_WRITE: begin
        // Only a hit on a dirty slot reaches the disk.
        r.hit = (pos >= 0);
        if (pos >= 0 && slot_dirty[pos]) begin
          r.write_valid = 1'b1;
          r.write_address = addr;
          r.write_value = slot_word[pos];
        end
      end
      default: begin
        // Modify loads on a miss, then steps the value and marks it dirty.
        if (pos >= 0) begin
          r.hit = 1'b1;
        end else begin
          pos = claim_slot(addr, data, wb, wb_addr, wb_val);
          r.disk_read = 1'b1;
          r.write_valid = wb;
          r.write_address = wb_addr;
          r.write_value = wb_val;
        end
        slot_word[pos] = down ? slot_word[pos] + WORD_MINUS : slot_word[pos] + WORD_PLUS;
        slot_dirty[pos] = 1'b1;
      end
    endcase
    expected_results = {expected_results, r};
  endtask

  // Port monitor: configuration first, then requests, then results.
  always @(posedge clk) begin
    sector_result_t seen;
    sector_result_t want;
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_sector[i] = '0;
        slot_word[i] = WORD_ZERO;
        slot_dirty[i] = 1'b0;
      end
      fill_count = 0;
      fifo_ptr = 0;
      bypass = 1'b0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_write_en) begin
        bypass = cfg_write_data;
      end
      if (in_valid && in_ready) begin
        predict_request(action, sector_address, disk_data, modify_down);
      end
      if (out_valid && out_ready) begin
        seen.hit = hit;
        seen.disk_read = disk_read;
        seen.write_valid = write_valid;
        seen.write_address = write_address;
        seen.write_value = write_value;
        seen.last_result = last_result;
        if (expected_results.size() == 0) begin
          if (fail_count < REPORT_LIMIT) begin
            $display("%0t: unexpected result transaction: hit=%b rd=%b wv=%b wa=%h val=%h last=%b",
                     $realtime, seen.hit, seen.disk_read, seen.write_valid,
                     seen.write_address, seen.write_value, seen.last_result);
          end
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (seen.hit !== want.hit || seen.disk_read !== want.disk_read ||
              seen.write_valid !== want.write_valid ||
              seen.write_address !== want.write_address ||
              seen.write_value !== want.write_value ||
              seen.last_result !== want.last_result) begin
            if (fail_count < REPORT_LIMIT) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected hit=%b rd=%b wv=%b wa=%h val=%h last=%b",
                       want.hit, want.disk_read, want.write_valid,
                       want.write_address, want.write_value, want.last_result);
              $display("  actual   hit=%b rd=%b wv=%b wa=%h val=%h last=%b",
                       seen.hit, seen.disk_read, seen.write_valid,
                       seen.write_address, seen.write_value, seen.last_result);
            end
            fail_count++;
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the FIFO write-back sector cache: clock, reset, request and
// configuration stimulus, result back-pressure and the final verdict.
// Depends on fwbc_pkg, fifo_write_back_buffer_cache_top and sector_cache_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fwbc_pkg::*;

  localparam int SLOT_COUNT   = DEFAULT_SLOT_COUNT;
  localparam int DRAIN_CYCLES = 2 * SLOT_COUNT + 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int POOL_SIZE    = 12;

  logic    clk;
  logic    rst;
  logic    cfg_write_en;
  logic    cfg_write_data;
  logic    in_valid;
  logic    in_ready;
  action_t action;
  sector_t sector_address;
  word_t   disk_data;
  logic    modify_down;
  logic    out_valid;
  logic    out_ready;
  logic    hit;
  logic    disk_read;
  logic    write_valid;
  sector_t write_address;
  word_t   write_value;
  logic    last_result;
  int      fail_count;
  int      pending;

  // Set for stretches of the run in which neither side idles.
  logic    quiet;
  int      cycle_count = 0;
  sector_t sector_pool [POOL_SIZE];

  fifo_write_back_buffer_cache_top #(.SLOT_COUNT(SLOT_COUNT)) uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .sector_address (sector_address),
    .disk_data      (disk_data),
    .modify_down    (modify_down),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hit            (hit),
    .disk_read      (disk_read),
    .write_valid    (write_valid),
    .write_address  (write_address),
    .write_value    (write_value),
    .last_result    (last_result)
  );

  sector_cache_checker #(.SLOT_COUNT(SLOT_COUNT)) cache_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .sector_address (sector_address),
    .disk_data      (disk_data),
    .modify_down    (modify_down),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hit            (hit),
    .disk_read      (disk_read),
    .write_valid    (write_valid),
    .write_address  (write_address),
    .write_value    (write_value),
    .last_result    (last_result),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    return quiet ? 0 : $urandom_range(0, 16);
  endfunction

  // Result side: a random stall before each result transaction.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk iff !rst);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk iff (out_valid && out_ready));
      @(negedge clk);
    end
  end

  // Presents one request after a random gap; entered and left at a falling edge.
  task automatic send_item(action_t act, sector_t addr, word_t data, logic down);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    sector_address <= addr;
    disk_data <= data;
    modify_down <= down;
    @(posedge clk iff in_ready);
    @(negedge clk);
  endtask

  // Stops the sender, waits for every result, then writes the mode register.
  task automatic set_mode(logic bypass_on);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= bypass_on;
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // Random requests, mostly on a small set of sectors so that hits and
  // evictions are frequent.
  task automatic random_phase(int count);
    action_t act;
    sector_t addr;
    int pick;
    for (int i = 0; i < POOL_SIZE; i++) begin
      sector_pool[i] = sector_t'($urandom);
    end
    for (int k = 0; k < count; k++) begin
      if (k % 20 == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        act = ACT_READ;
      end else if (pick < 60) begin
        act = ACT_WRITE;
      end else if (pick < 90) begin
        act = ACT_MODIFY;
      end else begin
        act = ACT_FLUSH;
      end
      if ($urandom_range(0, 4) == 0) begin
        addr = sector_t'($urandom);
      end else begin
        addr = sector_pool[$urandom_range(0, POOL_SIZE - 1)];
      end
      send_item(act, addr, word_t'($urandom), logic'($urandom_range(0, 1)));
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    quiet = 1'b0;
    cfg_write_en = 1'b0;
    cfg_write_data = 1'b0;
    in_valid = 1'b0;
    action = ACT_READ;
    sector_address = '0;
    disk_data = WORD_ZERO;
    modify_down = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    set_mode(1'b0);

    // Directed cache-mode sequence: empty flush, hits, wrap, evictions, full flush.
    send_item(ACT_FLUSH,  16'h0000, 32'sh0000_0000, 1'b0);
    send_item(ACT_READ,   16'h0000, 32'sh7FFF_FFFF, 1'b0);
    send_item(ACT_READ,   16'h0000, 32'sh0000_0000, 1'b1);
    send_item(ACT_WRITE,  16'h0000, 32'sh1111_1111, 1'b0);
    send_item(ACT_WRITE,  16'h1234, 32'sh2222_2222, 1'b1);
    send_item(ACT_MODIFY, 16'h0000, 32'sh0000_0000, 1'b0);
    send_item(ACT_WRITE,  16'h0000, 32'sh0000_0000, 1'b0);
    send_item(ACT_MODIFY, 16'hFFFF, 32'sh8000_0000, 1'b1);
    send_item(ACT_READ,   16'hA5A5, 32'shFFFF_FFFF, 1'b0);
    send_item(ACT_READ,   16'h5A5A, 32'sh0000_0000, 1'b1);
    send_item(ACT_READ,   16'h0001, 32'sh5555_5555, 1'b0);
    send_item(ACT_READ,   16'h8000, 32'shAAAA_AAAA, 1'b1);
    send_item(ACT_READ,   16'h7FFF, 32'sh0000_0001, 1'b0);
    send_item(ACT_READ,   16'hFFFE, 32'sh8000_0001, 1'b1);
    send_item(ACT_READ,   16'h4321, 32'sh1357_9BDF, 1'b0);
    send_item(ACT_READ,   16'h4322, 32'sh2468_ACE0, 1'b0);
    send_item(ACT_READ,   16'h4323, 32'shFEDC_BA98, 1'b1);
    send_item(ACT_MODIFY, 16'h5A5A, 32'sh0000_0000, 1'b1);
    send_item(ACT_FLUSH,  16'hFFFF, 32'shFFFF_FFFF, 1'b1);

    // Directed bypass sequence.
    set_mode(1'b1);
    send_item(ACT_READ,   16'hFFFF, 32'sh7FFF_FFFF, 1'b0);
    send_item(ACT_WRITE,  16'h8001, 32'sh8000_0000, 1'b1);
    send_item(ACT_MODIFY, 16'h00FF, 32'shFFFF_FFFF, 1'b0);
    send_item(ACT_MODIFY, 16'hFF00, 32'sh0000_0000, 1'b1);
    send_item(ACT_FLUSH,  16'h0000, 32'sh0000_0000, 1'b0);

    // Random phases across both modes; each boundary drains all results.
    set_mode(1'b0);
    random_phase(80);
    set_mode(1'b1);
    random_phase(30);
    set_mode(1'b0);
    random_phase(90);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
